### rtl/encoder_and_button_input_unit_macros.svh
// Assertion macros for the encoder and button input unit top level.
`ifndef ENCODER_AND_BUTTON_INPUT_UNIT_MACROS_SVH
`define ENCODER_AND_BUTTON_INPUT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EBIU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ebiu assertion failed: same-cycle check");

// Next-cycle implication, sampled on clock, off during reset.
`define EBIU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ebiu assertion failed: next-cycle check");

`endif

### rtl/ebiu_pkg.sv
// Package: payload types, codes and tables of the encoder and button input unit.
`timescale 1ns / 1ps

package ebiu_pkg;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] CSR_BUTTON_DIVIDER = 2'd0;
   localparam logic [1:0] CSR_RPT_DELAY      = 2'd1;
   localparam logic [1:0] CSR_RPT_INTERVAL   = 2'd2;

   localparam logic [7:0] BUTTON_DIVIDER_RST = 8'd100;
   localparam logic [7:0] RPT_DELAY_RST      = 8'd100;
   localparam logic [7:0] RPT_INTERVAL_RST   = 8'd20;

   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_READ_CLEAR = 3'd1;
   localparam logic [2:0] FUNC_TAKE_PRESS = 3'd2;
   localparam logic [2:0] FUNC_TAKE_SHORT = 3'd3;
   localparam logic [2:0] FUNC_TAKE_LONG  = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic       phase_a;
      logic       phase_b;
      logic       key_pin;
   } req_type;

   typedef struct packed {
      logic signed [7:0] count_value;
      logic              taken;
      logic              key_down;
      logic              press_pending;
      logic              repeat_pending;
   } rsp_type;

   // Debounce and repeat state of the key.
   typedef struct packed {
      logic       down;
      logic       vert_low;
      logic       vert_high;
      logic       press;
      logic       rpt_latch;
      logic [7:0] timer;
   } key_state_type;

   // Quadrature transition table, indexed by {old A, old B, new A, new B}.
   function automatic logic [7:0] step_delta(input logic [3:0] hist);
      logic [7:0] d;
      case (hist)
         4'd2, 4'd13: d = 8'hFF;
         4'd7, 4'd8:  d = 8'h01;
         default:     d = 8'h00;
      endcase
      return d;
   endfunction

endpackage

### rtl/ebiu_debounce.sv
// Key debounce step: two-bit vertical counter, press latch and repeat timer.
`timescale 1ns / 1ps

module ebiu_debounce (
   input  ebiu_pkg::key_state_type key_cur,
   input  logic                    key_pin,
   input  logic [7:0]              rpt_delay,
   input  logic [7:0]              rpt_interval,
   output ebiu_pkg::key_state_type key_nxt
);

   logic       chg;
   logic       vl;
   logic       vh;
   logic       flip;
   logic       down;
   logic [7:0] tmr_base;
   logic [7:0] tmr_dec;

   always_comb begin
      // pin is active low: change when debounced state differs from pressed level
      chg  = key_cur.down ^ ~key_pin;
      vl   = ~(key_cur.vert_low & chg);
      vh   = vl ^ (key_cur.vert_high & chg);
      flip = chg & vl & vh;
      down = key_cur.down ^ flip;

      tmr_base = down ? key_cur.timer : rpt_delay;
      tmr_dec  = tmr_base - 8'd1;

      key_nxt.down      = down;
      key_nxt.vert_low  = vl;
      key_nxt.vert_high = vh;
      key_nxt.press     = key_cur.press | (down & flip);
      if (tmr_dec == 8'd0) begin
         key_nxt.timer     = rpt_interval;
         key_nxt.rpt_latch = key_cur.rpt_latch | down;
      end else begin
         key_nxt.timer     = tmr_dec;
         key_nxt.rpt_latch = key_cur.rpt_latch;
      end
   end

endmodule

### rtl/encoder_and_button_input_unit.sv
// Top level: quadrature decoder and debounced key with APB-style register port.
// An accepted request is held in the input register and its result is written
// to the result register when the output is free; one item per cycle sustained
// while the receiver does not stall, with a combinational state update between.
// Reset (synchronous, active high): all state cleared, registers at defaults,
// both channels empty.
`timescale 1ns / 1ps

module encoder_and_button_input_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ebiu_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ebiu_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ebiu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   `include "encoder_and_button_input_unit_macros.svh"

   logic [7:0]              button_divider_ff;
   logic [7:0]              rpt_delay_ff;
   logic [7:0]              rpt_interval_ff;

   logic                    pipe_valid_ff;
   ebiu_pkg::req_type       pipe_data_ff;
   logic                    rsp_valid_ff;
   ebiu_pkg::rsp_type       rsp_data_ff;
   ebiu_pkg::rsp_type       rsp_data_in;

   logic [3:0]              hist_ff;
   logic [3:0]              hist_in;
   logic [7:0]              count_ff;
   logic [7:0]              count_in;
   logic [7:0]              div_ff;
   logic [7:0]              div_in;
   ebiu_pkg::key_state_type key_ff;
   ebiu_pkg::key_state_type key_in;
   ebiu_pkg::key_state_type key_step;

   logic                    advance;
   logic                    csr_wr;
   logic [7:0]              div_inc;
   logic                    taken;
   logic [7:0]              shown;
   logic                    adv_tick;
   logic                    adv_read;
   logic                    adv_take;

   assign advance    = pipe_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !pipe_valid_ff || advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   assign adv_tick = advance && (pipe_data_ff.func == ebiu_pkg::FUNC_TICK);
   assign adv_read = advance && (pipe_data_ff.func == ebiu_pkg::FUNC_READ_CLEAR);
   assign adv_take = advance && (pipe_data_ff.func == ebiu_pkg::FUNC_TAKE_PRESS ||
                                 pipe_data_ff.func == ebiu_pkg::FUNC_TAKE_SHORT ||
                                 pipe_data_ff.func == ebiu_pkg::FUNC_TAKE_LONG);

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         button_divider_ff <= ebiu_pkg::BUTTON_DIVIDER_RST;
         rpt_delay_ff      <= ebiu_pkg::RPT_DELAY_RST;
         rpt_interval_ff   <= ebiu_pkg::RPT_INTERVAL_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            ebiu_pkg::CSR_BUTTON_DIVIDER: button_divider_ff <= csr_pwdata[7:0];
            ebiu_pkg::CSR_RPT_DELAY:      rpt_delay_ff      <= csr_pwdata[7:0];
            ebiu_pkg::CSR_RPT_INTERVAL:   rpt_interval_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ebiu_pkg::CSR_BUTTON_DIVIDER: csr_prdata = {24'd0, button_divider_ff};
         ebiu_pkg::CSR_RPT_DELAY:      csr_prdata = {24'd0, rpt_delay_ff};
         ebiu_pkg::CSR_RPT_INTERVAL:   csr_prdata = {24'd0, rpt_interval_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   ebiu_debounce u_debounce (
      .key_cur      (key_ff),
      .key_pin      (pipe_data_ff.key_pin),
      .rpt_delay    (rpt_delay_ff),
      .rpt_interval (rpt_interval_ff),
      .key_nxt      (key_step)
   );

   // State update for the item held in the input register
   always_comb begin
      hist_in  = hist_ff;
      count_in = count_ff;
      div_in   = div_ff;
      key_in   = key_ff;
      taken    = 1'b0;
      div_inc  = div_ff + 8'd1;
      shown    = count_ff;

      case (pipe_data_ff.func)
         ebiu_pkg::FUNC_TICK: begin
            if (div_ff == 8'd0) begin
               key_in = key_step;
            end
            // divider of zero acts as one; a lowered divider snaps back to zero
            div_in   = (div_inc >= button_divider_ff) ? 8'd0 : div_inc;
            hist_in  = {hist_ff[1:0], pipe_data_ff.phase_a, pipe_data_ff.phase_b};
            count_in = count_ff + ebiu_pkg::step_delta(hist_in);
            shown    = count_in;
         end
         ebiu_pkg::FUNC_READ_CLEAR: begin
            count_in = 8'd0;
         end
         ebiu_pkg::FUNC_TAKE_PRESS: begin
            taken        = key_ff.press;
            key_in.press = 1'b0;
         end
         ebiu_pkg::FUNC_TAKE_SHORT: begin
            taken        = key_ff.press & ~key_ff.down;
            key_in.press = key_ff.press ^ taken;
         end
         ebiu_pkg::FUNC_TAKE_LONG: begin
            taken            = key_ff.press & key_ff.rpt_latch;
            key_in.rpt_latch = 1'b0;
            key_in.press     = key_ff.press ^ taken;
         end
         default: ;
      endcase

      rsp_data_in.count_value    = shown;
      rsp_data_in.taken          = taken;
      rsp_data_in.key_down       = key_in.down;
      rsp_data_in.press_pending  = key_in.press;
      rsp_data_in.repeat_pending = key_in.rpt_latch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hist_ff       <= 4'd0;
         count_ff      <= 8'd0;
         div_ff        <= 8'd0;
         key_ff        <= '0;
      end else begin
         if (req_ready) begin
            pipe_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            hist_ff      <= hist_in;
            count_ff     <= count_in;
            div_ff       <= div_in;
            key_ff       <= key_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pipe_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `EBIU_ASSERT_NEXT(a_read_clears, adv_read, count_ff == 8'd0)
   `EBIU_ASSERT_NEXT(a_tick_shows_count, adv_tick, rsp_data_ff.count_value == count_ff)
   `EBIU_ASSERT_NEXT(a_taken_only_take, advance && !adv_take, !rsp_data_ff.taken)
   `EBIU_ASSERT_NOW(a_press_from_tick, $rose(key_ff.press), $past(adv_tick))

endmodule

### tb/tb_top.sv
// Self-checking testbench for the encoder and button input unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int DRAIN_CYCLES = 4;
   localparam int TIMEOUT_NS   = 400_000;

   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   localparam int RX_ALWAYS = 0;
   localparam int RX_RANDOM = 1;
   localparam int RX_SPARSE = 2;

   // Count change per {old A, old B, new A, new B}.
   localparam logic [7:0] COUNT_DELTA [16] = '{
      8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
      8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};

   localparam logic [1:0] GRAY_CODE [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

   // Directed items as {func, phase_a, phase_b, key_pin}; run at reset settings.
   localparam int NUM_DIRECTED = 19;
   localparam logic [5:0] DIRECTED [NUM_DIRECTED] = '{
      {ebiu_pkg::FUNC_TICK, 3'b001},       // first tick after reset takes a debounce step
      {ebiu_pkg::FUNC_TICK, 3'b010},
      {ebiu_pkg::FUNC_TICK, 3'b110},
      {ebiu_pkg::FUNC_TICK, 3'b100},
      {ebiu_pkg::FUNC_TICK, 3'b000},
      {ebiu_pkg::FUNC_TICK, 3'b101},       // reverse direction
      {ebiu_pkg::FUNC_TICK, 3'b111},
      {ebiu_pkg::FUNC_TICK, 3'b011},
      {ebiu_pkg::FUNC_TICK, 3'b000},
      {ebiu_pkg::FUNC_TICK, 3'b110},       // both phases flip at once
      {ebiu_pkg::FUNC_READ_CLEAR, 3'b111},
      {ebiu_pkg::FUNC_READ_CLEAR, 3'b000},
      {ebiu_pkg::FUNC_TAKE_PRESS, 3'b000},
      {ebiu_pkg::FUNC_TAKE_SHORT, 3'b101},
      {ebiu_pkg::FUNC_TAKE_LONG, 3'b010},
      {FUNC_UNUSED_LO, 3'b111},
      {FUNC_UNUSED_LO + 3'd1, 3'b000},
      {FUNC_UNUSED_HI, 3'b110},
      {ebiu_pkg::FUNC_TICK, 3'b100}};

   // Register settings per random phase; the spin phase turns the encoder one
   // way with no reads so the count wraps, and holds the key long enough for
   // a zero reload to time out.
   localparam int NUM_PHASES = 6;
   localparam logic [7:0] PH_DIVIDER [NUM_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd1, 8'd255, 8'd3};
   localparam logic [7:0] PH_START [NUM_PHASES]   = '{8'd4, 8'd6, 8'd1, 8'd0, 8'd255, 8'd2};
   localparam logic [7:0] PH_NEXT [NUM_PHASES]    = '{8'd2, 8'd3, 8'd1, 8'd0, 8'd255, 8'd255};
   localparam int PH_ITEMS [NUM_PHASES] = '{120, 100, 60, 400, 40, 80};
   localparam int PH_HOLD [NUM_PHASES]  = '{30, 30, 12, 290, 20, 40};
   localparam bit PH_SPIN [NUM_PHASES]  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

   class encoder_key_scoreboard;
      logic [7:0]        divider_reg;
      logic [7:0]        start_reg;
      logic [7:0]        next_reg;
      logic [3:0]        history;
      logic [7:0]        count;
      logic [7:0]        div_count;
      logic [7:0]        timer;
      logic              down;
      logic              vlow;
      logic              vhigh;
      logic              press;
      logic              rpt;
      ebiu_pkg::rsp_type expected_rsp[$];
      int                errors;

      function new();
         divider_reg = ebiu_pkg::BUTTON_DIVIDER_RST;
         start_reg   = ebiu_pkg::RPT_DELAY_RST;
         next_reg    = ebiu_pkg::RPT_INTERVAL_RST;
         history     = '0;
         count       = '0;
         div_count   = '0;
         timer       = '0;
         down        = 1'b0;
         vlow        = 1'b0;
         vhigh       = 1'b0;
         press       = 1'b0;
         rpt         = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            ebiu_pkg::CSR_BUTTON_DIVIDER: divider_reg = val;
            ebiu_pkg::CSR_RPT_DELAY:      start_reg = val;
            ebiu_pkg::CSR_RPT_INTERVAL:   next_reg = val;
            default: ;
         endcase
      endfunction

      // Two-bit vertical counter: the key flips after four equal samples.
      function void debounce(logic pin);
         logic chg;
         chg   = down ^ ~pin;
         vlow  = ~(vlow & chg);
         vhigh = vlow ^ (vhigh & chg);
         chg   = chg & vlow & vhigh;
         down  = down ^ chg;
         press = press | (down & chg);
         if (!down) timer = start_reg;
         timer = timer - 8'd1;
         if (timer == 8'd0) begin
            timer = next_reg;
            rpt   = rpt | down;
         end
      endfunction

      function void note_input(ebiu_pkg::req_type item);
         ebiu_pkg::rsp_type want;
         logic [7:0]        shown;
         logic              taken;
         logic              had_rpt;
         shown = count;
         taken = 1'b0;
         case (item.func)
            ebiu_pkg::FUNC_TICK: begin
               if (div_count == 8'd0) debounce(item.key_pin);
               div_count = div_count + 8'd1;
               if (div_count >= divider_reg) div_count = 8'd0;
               history = {history[1:0], item.phase_a, item.phase_b};
               count   = count + COUNT_DELTA[history];
               shown   = count;
            end
            ebiu_pkg::FUNC_READ_CLEAR: count = 8'd0;
            ebiu_pkg::FUNC_TAKE_PRESS: begin
               taken = press;
               press = 1'b0;
            end
            ebiu_pkg::FUNC_TAKE_SHORT: begin
               taken = press & ~down;
               press = press ^ taken;
            end
            ebiu_pkg::FUNC_TAKE_LONG: begin
               had_rpt = rpt;
               rpt     = 1'b0;
               taken   = press & had_rpt;
               press   = press ^ taken;
            end
            default: ;
         endcase
         want.count_value    = shown;
         want.taken          = taken;
         want.key_down       = down;
         want.press_pending  = press;
         want.repeat_pending = rpt;
         expected_rsp.push_back(want);
      endfunction

      function void report(string field, logic signed [7:0] want, logic signed [7:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(ebiu_pkg::rsp_type got);
         ebiu_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: result transfer with none expected, actual %p", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.count_value !== want.count_value)
            report("count_value", want.count_value, got.count_value);
         if (got.taken !== want.taken)
            report("taken", 8'(want.taken), 8'(got.taken));
         if (got.key_down !== want.key_down)
            report("key_down", 8'(want.key_down), 8'(got.key_down));
         if (got.press_pending !== want.press_pending)
            report("press_pending", 8'(want.press_pending), 8'(got.press_pending));
         if (got.repeat_pending !== want.repeat_pending)
            report("repeat_pending", 8'(want.repeat_pending), 8'(got.repeat_pending));
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   ebiu_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   ebiu_pkg::rsp_type               rsp_data;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ebiu_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   encoder_key_scoreboard sb;

   int         burst_left = 0;
   logic [1:0] enc_pos = 2'd0;
   bit         enc_dir = 1'b0;
   bit         key_level = 1'b1;
   bit         bouncy = 1'b0;
   int         hold_left = 0;

   int rx_mode = RX_ALWAYS;
   int rx_left = 0;
   int rx_count = 0;

   encoder_and_button_input_unit u_top (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // Receiver stalls: ready is always high, random or sparse, in modes redrawn at random.
   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_ALWAYS, RX_SPARSE);
            rx_left <= $urandom_range(16, 96);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= (rx_count % 4 == 0);
         endcase
      end
   end

   task automatic send_item(input ebiu_pkg::req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Hold off the sender until every result is back, then let the pipe drain.
   task automatic settle();
      req_valid <= 1'b0;
      // let the last accepted transfer be noted before counting
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, val);
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== val) begin
         sb.errors++;
         $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                  $time, idx, val, csr_prdata[7:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input int items, input int hold_max, input bit spin);
      ebiu_pkg::req_type item;
      int                roll;
      for (int i = 0; i < items; i++) begin
         item.phase_a = 1'($urandom_range(0, 1));
         item.phase_b = 1'($urandom_range(0, 1));
         item.key_pin = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         if (roll < (spin ? 5 : 22)) begin
            if (spin || roll >= 2)
               item.func = 3'($urandom_range(
                  spin ? ebiu_pkg::FUNC_TAKE_PRESS : ebiu_pkg::FUNC_READ_CLEAR,
                  ebiu_pkg::FUNC_TAKE_LONG));
            else
               item.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
         end else begin
            item.func = ebiu_pkg::FUNC_TICK;
            if (hold_left == 0) begin
               if (spin || $urandom_range(0, 3) != 0) key_level = ~key_level;
               bouncy = !spin && $urandom_range(0, 6) == 0;
               if (!spin) hold_left = $urandom_range(1, hold_max);
               else if (key_level) hold_left = $urandom_range(4, 20);
               else hold_left = hold_max;
            end
            hold_left--;
            item.key_pin = bouncy ? 1'($urandom_range(0, 1)) : key_level;
            roll = $urandom_range(0, 99);
            if (spin || roll < 60) begin
               if (!spin && roll < 6) enc_dir = ~enc_dir;
               enc_pos = enc_dir ? enc_pos + 2'd1 : enc_pos - 2'd1;
            end else if (roll >= 92) begin
               enc_pos = enc_pos + 2'd2;   // skipped state, both phases change
            end
            {item.phase_a, item.phase_b} = GRAY_CODE[enc_pos];
         end
         send_item(item);
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_DIRECTED; i++) send_item(ebiu_pkg::req_type'(DIRECTED[i]));
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_csr(ebiu_pkg::CSR_BUTTON_DIVIDER, PH_DIVIDER[p]);
         write_csr(ebiu_pkg::CSR_RPT_DELAY, PH_START[p]);
         write_csr(ebiu_pkg::CSR_RPT_INTERVAL, PH_NEXT[p]);
         enc_dir = 1'($urandom_range(0, 1));
         run_phase(PH_ITEMS[p], PH_HOLD[p], PH_SPIN[p]);
      end
      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/ebiu_pkg.sv
rtl/ebiu_debounce.sv
rtl/encoder_and_button_input_unit.sv
tb/tb_top.sv
